// File: src/sactc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Set-associative cache tag controller package
// Shared types and codes used by the front, back and top-level modules.
// ----------------------------------------------------------------------------
package sactc_pkg;

   localparam int unsigned ADDR_W = 32;

   // Configuration register indexes.
   localparam logic CSR_WT_MODE = 1'b0;
   localparam logic CSR_ALLOC_ON_WRITE = 1'b1;

   // Access kinds.
   localparam logic CMD_READ  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   // Result record carried from the back end to the response ports.
   typedef struct packed {
      logic              hit;
      logic [1:0]        way_used;
      logic              fetch_lower;
      logic              write_lower;
      logic              evict_dirty;
      logic [ADDR_W-1:0] victim_addr;
   } rsp_type;

endpackage : sactc_pkg
`default_nettype wire

// File: src/set_assoc_cache_tag_controller.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Set-associative cache tag controller
// LRU replacement, write-back or write-through, optional write-allocate.
// ----------------------------------------------------------------------------
// Channel    Handshake             Payload
// request    start / busy          req_cmd, req_addr
// response   rsp_strobe (1 cycle)  rsp_hit .. rsp_victim_addr
// csr        csr_valid / csr_ready csr_index, csr_wdata
//
// Each transaction passes three back-end states: ST_IDLE pops the queue and
// issues the RAM read, ST_READ waits for the registered read data, ST_EXEC
// compares and updates; the result strobe is registered from ST_EXEC.
// With registered tag, LRU and valid/dirty reads, a new pop follows ST_EXEC.
// The front queue holds two transactions, so start is taken while the back
// end works. Reset is synchronous and clears the per-set written marks, so
// no clearing pass is needed. The receiver cannot stall the response.
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_controller #(
   parameter int unsigned SETS = 64,
   parameter int unsigned WAYS = 4,
   parameter int unsigned BLOCK_BYTES = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_cmd,
   input  wire logic [31:0] req_addr,
   output logic             rsp_strobe,
   output logic             rsp_hit,
   output logic [1:0]       rsp_way_used,
   output logic             rsp_fetch_lower,
   output logic             rsp_write_lower,
   output logic             rsp_evict_dirty,
   output logic [31:0]      rsp_victim_addr,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [31:0] csr_wdata
);
   import sactc_pkg::*;

   localparam int unsigned OFF_W = $clog2(BLOCK_BYTES);
   localparam int unsigned SET_W = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int unsigned IDX_W = (SETS > 1) ? $clog2(SETS) : 0;
   localparam int unsigned TAG_W = 32 - OFF_W - IDX_W;

   logic wt_mode_ff, alloc_ff;

   // Registers are always writable; software writes them only when idle, the block itself does not enforce it.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         wt_mode_ff <= 1'b0;
         alloc_ff   <= 1'b1;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_WT_MODE:        wt_mode_ff <= csr_wdata[0];
            CSR_ALLOC_ON_WRITE: alloc_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   logic             q_valid, q_cmd, q_pop;
   logic [SET_W-1:0] q_set;
   logic [TAG_W-1:0] q_tag;
   rsp_type          rsp;

   sactc_front #(.SET_W(SET_W), .IDX_W(IDX_W), .TAG_W(TAG_W), .OFF_W(OFF_W),
      .QDEPTH(2)) u_front (
      .clock(clock), .reset(reset), .start(start), .req_cmd(req_cmd),
      .req_addr(req_addr), .busy(busy), .q_valid(q_valid), .q_cmd(q_cmd),
      .q_set(q_set), .q_tag(q_tag), .q_pop(q_pop));

   sactc_back #(.SETS(SETS), .WAYS(WAYS), .SET_W(SET_W), .TAG_W(TAG_W),
      .OFF_W(OFF_W)) u_back (
      .clock(clock), .reset(reset), .wt_mode(wt_mode_ff),
      .alloc_on_write(alloc_ff), .q_valid(q_valid), .q_cmd(q_cmd),
      .q_set(q_set), .q_tag(q_tag), .q_pop(q_pop), .rsp_strobe(rsp_strobe),
      .rsp(rsp));

   assign rsp_hit         = rsp.hit;
   assign rsp_way_used    = rsp.way_used;
   assign rsp_fetch_lower = rsp.fetch_lower;
   assign rsp_write_lower = rsp.write_lower;
   assign rsp_evict_dirty = rsp.evict_dirty;
   assign rsp_victim_addr = rsp.victim_addr;

`ifndef SYNTHESIS
   a_fetch_not_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_hit && rsp_fetch_lower)) else $error("hit with refill");
   a_evict_needs_fetch: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_evict_dirty) |-> rsp_fetch_lower)
      else $error("eviction without refill");
   a_victim_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_evict_dirty) |-> (rsp_victim_addr == '0))
      else $error("victim address without eviction");
`endif
endmodule : set_assoc_cache_tag_controller
`default_nettype wire

// File: src/sactc_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module sactc_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                                      clock,
   input  wire logic                                      wr_en,
   input  wire logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                          wr_data,
   input  wire logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                          rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule : sactc_ram
`default_nettype wire

// File: src/sactc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Tag controller front end
// Accepts accesses, splits the address into set and tag and queues them.
// ----------------------------------------------------------------------------
module sactc_front #(
   parameter int unsigned SET_W = 6,
   parameter int unsigned IDX_W = 6,
   parameter int unsigned TAG_W = 20,
   parameter int unsigned OFF_W = 6,
   parameter int unsigned QDEPTH = 2
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic                      req_cmd,
   input  wire logic [31:0]               req_addr,
   output logic                           busy,
   output logic                           q_valid,
   output logic                           q_cmd,
   output logic [SET_W-1:0]               q_set,
   output logic [TAG_W-1:0]               q_tag,
   input  wire logic                      q_pop
);
   import sactc_pkg::*;

   localparam int unsigned PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int unsigned ENT_W = 1 + SET_W + TAG_W;

   logic [ENT_W-1:0] q_ff [QDEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [PTR_W:0]   cnt_ff, cnt_in;
   logic             push;
   logic [SET_W-1:0] set_w;
   logic [TAG_W-1:0] tag_w;

   assign busy  = (cnt_ff == (PTR_W+1)'(QDEPTH));
   assign push  = start && !busy;
   // With a single set the set field is empty and the index is zero.
   assign set_w = (IDX_W == 0) ? '0 : SET_W'(req_addr >> OFF_W);
   assign tag_w = TAG_W'(req_addr >> (OFF_W + IDX_W));

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(QDEPTH-1)) ? '0 : wr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_in = (rd_ff == PTR_W'(QDEPTH-1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !q_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!push && q_pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         q_ff[wr_ff] <= {req_cmd, set_w, tag_w};
      end
   end

   assign q_valid = (cnt_ff != '0);
   assign {q_cmd, q_set, q_tag} = q_ff[rd_ff];

`ifndef SYNTHESIS
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid) else $error("pop from empty queue");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (PTR_W+1)'(QDEPTH)) else $error("queue overflow");
   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (push && !q_pop) |=> (cnt_ff == $past(cnt_ff) + 1'b1))
      else $error("queue count lost a push");
`endif
endmodule : sactc_front
`default_nettype wire

// File: src/sactc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Tag controller back end
// Looks up the set, picks hit or victim way, updates tags, bits and LRU.
// ----------------------------------------------------------------------------
module sactc_back #(
   parameter int unsigned SETS = 64,
   parameter int unsigned WAYS = 4,
   parameter int unsigned SET_W = 6,
   parameter int unsigned TAG_W = 20,
   parameter int unsigned OFF_W = 6
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               wt_mode,
   input  wire logic               alloc_on_write,
   input  wire logic               q_valid,
   input  wire logic               q_cmd,
   input  wire logic [SET_W-1:0]   q_set,
   input  wire logic [TAG_W-1:0]   q_tag,
   output logic                    q_pop,
   output logic                    rsp_strobe,
   output sactc_pkg::rsp_type      rsp
);
   import sactc_pkg::*;

   localparam int unsigned WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int unsigned SA_W  = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int unsigned IDX_W = (SETS > 1) ? $clog2(SETS) : 0;
   localparam int unsigned LRU_W = WAYS * WAY_W;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_READ = 3'b010,
      ST_EXEC = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic             cmd_ff;
   logic [SET_W-1:0] set_ff;
   logic [TAG_W-1:0] tag_ff;
   logic [SA_W-1:0]  sidx, rd_sidx;
   logic             strobe_ff;
   rsp_type          rsp_ff;

   // Per-set state lives in RAMs: tags, LRU order and the valid and dirty
   // rows. A per-set written mark, cleared by reset, makes a never-written
   // set read as all invalid with the reset LRU order.
   logic [SETS-1:0]  lru_wr_ff;

   logic                   tag_we, lru_we;
   logic [WAYS*TAG_W-1:0]  tag_wd, tag_rd;
   logic [LRU_W-1:0]       lru_wd, lru_rd, lru_cur, lru_rst;
   logic [2*WAYS-1:0]      vd_wd, vd_rd, vd_cur;

   assign sidx = SA_W'(set_ff);
   // The read is issued at the pop edge and then held on the popped set.
   assign rd_sidx = (state_ff == ST_IDLE) ? SA_W'(q_set) : sidx;

   sactc_ram #(.WIDTH(WAYS*TAG_W), .DEPTH(SETS)) u_tag_ram (
      .clock(clock), .wr_en(tag_we), .wr_addr(sidx), .wr_data(tag_wd),
      .rd_addr(rd_sidx), .rd_data(tag_rd));

   sactc_ram #(.WIDTH(LRU_W), .DEPTH(SETS)) u_lru_ram (
      .clock(clock), .wr_en(lru_we), .wr_addr(sidx), .wr_data(lru_wd),
      .rd_addr(rd_sidx), .rd_data(lru_rd));

   sactc_ram #(.WIDTH(2*WAYS), .DEPTH(SETS)) u_vd_ram (
      .clock(clock), .wr_en(lru_we), .wr_addr(sidx), .wr_data(vd_wd),
      .rd_addr(rd_sidx), .rd_data(vd_rd));

   always_comb begin
      for (int i = 0; i < WAYS; i++) begin
         lru_rst[i*WAY_W +: WAY_W] = WAY_W'(i);
      end
   end
   assign lru_cur = lru_wr_ff[sidx] ? lru_rd : lru_rst;
   assign vd_cur  = lru_wr_ff[sidx] ? vd_rd : '0;

   // Lookup and update.
   logic [WAYS-1:0]  vrow, drow, match, nvrow, ndrow;
   logic             found, bypass;
   logic [WAY_W-1:0] hway, vway, way;
   logic [WAY_W-1:0] order [WAYS];
   logic [WAY_W-1:0] norder [WAYS];
   logic [TAG_W-1:0] vtag;
   logic             seen;
   rsp_type          r;

   always_comb begin
      vrow  = vd_cur[WAYS +: WAYS];
      drow  = vd_cur[0 +: WAYS];
      found = 1'b0;
      hway  = '0;
      for (int i = 0; i < WAYS; i++) begin
         match[i] = vrow[i] && (tag_rd[i*TAG_W +: TAG_W] == tag_ff);
      end
      for (int i = WAYS-1; i >= 0; i--) begin
         if (match[i]) begin
            found = 1'b1;
            hway  = WAY_W'(i);
         end
      end
      for (int i = 0; i < WAYS; i++) begin
         order[i] = lru_cur[i*WAY_W +: WAY_W];
      end
      vway   = order[WAYS-1];
      bypass = !found && (cmd_ff == CMD_WRITE) && !alloc_on_write;
      way    = found ? hway : vway;
      vtag   = tag_rd[vway*TAG_W +: TAG_W];
      // Move way to the front; entries ahead of it shift back by one.
      seen = 1'b0;
      norder[0] = way;
      for (int i = 1; i < WAYS; i++) begin
         if (order[i-1] == way) begin
            seen = 1'b1;
         end
         norder[i] = seen ? order[i] : order[i-1];
      end
      for (int i = 0; i < WAYS; i++) begin
         lru_wd[i*WAY_W +: WAY_W] = norder[i];
      end
      tag_wd = tag_rd;
      tag_wd[vway*TAG_W +: TAG_W] = tag_ff;

      // A refill leaves the line valid and clean before the write lands.
      nvrow = vrow;
      ndrow = drow;
      if (!found) begin
         nvrow[way] = 1'b1;
         ndrow[way] = (cmd_ff == CMD_WRITE) && !wt_mode;
      end else if ((cmd_ff == CMD_WRITE) && !wt_mode) begin
         ndrow[way] = 1'b1;
      end
      vd_wd = {nvrow, ndrow};

      r = '0;
      r.hit = found;
      if (bypass) begin
         r.write_lower = 1'b1;
      end else begin
         r.way_used    = 2'(way);
         r.fetch_lower = !found;
         r.write_lower = (cmd_ff == CMD_WRITE) && wt_mode;
         if (!found && vrow[vway] && drow[vway]) begin
            r.evict_dirty = 1'b1;
            r.victim_addr = (32'(vtag) << (OFF_W + IDX_W)) | (32'(set_ff) << OFF_W);
         end
      end
   end

   logic exec;
   assign exec   = (state_ff == ST_EXEC);
   assign tag_we = exec && !found && !bypass;
   assign lru_we = exec && !bypass;
   assign q_pop  = (state_ff == ST_IDLE) && q_valid;

   always_comb begin
      case (state_ff)
         ST_IDLE: state_in = q_valid ? ST_READ : ST_IDLE;
         ST_READ: state_in = ST_EXEC;
         ST_EXEC: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
         lru_wr_ff <= '0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= exec;
         if (lru_we) begin
            lru_wr_ff[sidx] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cmd_ff <= q_cmd;
         set_ff <= q_set;
         tag_ff <= q_tag;
      end
      if (exec) begin
         rsp_ff <= r;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp        = rsp_ff;

`ifndef SYNTHESIS
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("back-to-back results");
   a_pop_follows: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (state_ff == ST_READ)) else $error("pop without lookup");
   a_refill_mark: assert property (@(posedge clock) disable iff (reset)
      tag_we |=> lru_wr_ff[$past(sidx)])
      else $error("refilled set not marked written");
`endif
endmodule : sactc_back
`default_nettype wire

// File: bench/set_assoc_cache_tag_controller_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Set-associative cache tag controller testbench
// Drives read and write accesses through the start/busy port and keeps its own
// copy of tags, valid and dirty bits and LRU order. Every response is checked
// field by field against the oldest predicted one, across all mode settings.
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_controller_test;
   import sactc_pkg::*;

   localparam int NSETS = 64;
   localparam int NWAYS = 4;
   localparam int BLK = 64;

   // One predicted or observed access outcome.
   typedef struct packed {
      logic        hit;
      logic [1:0]  way_used;
      logic        fetch_lower;
      logic        write_lower;
      logic        evict_dirty;
      logic [31:0] victim_addr;
   } outcome_type;

   // The scoreboard holds the shadow of the tag state and the queue of
   // outcomes still awaited from the block.
   class access_scoreboard;
      logic [25:0] tags [NSETS][NWAYS];
      bit          valid [NSETS][NWAYS];
      bit          dirty [NSETS][NWAYS];
      int          order [NSETS][NWAYS];
      bit          through_mode;
      bit          alloc_mode;
      outcome_type pending [$];
      int          errors;

      function new();
         for (int s = 0; s < NSETS; s++) begin
            for (int w = 0; w < NWAYS; w++) begin
               valid[s][w] = 0;
               dirty[s][w] = 0;
               tags[s][w] = '0;
               order[s][w] = w;
            end
         end
         through_mode = 0;
         alloc_mode = 1;
         errors = 0;
      endfunction

      // Move a way to the front of its set's recency list.
      function void touch(int s, int w);
         int pos;
         pos = NWAYS - 1;
         for (int i = NWAYS - 1; i >= 0; i--) begin
            if (order[s][i] == w) begin
               pos = i;
            end
         end
         for (int i = pos; i > 0; i--) begin
            order[s][i] = order[s][i-1];
         end
         order[s][0] = w;
      endfunction

      // Note an accepted access and queue the outcome it should produce.
      function void note_access(logic cmd, logic [31:0] addr);
         outcome_type o;
         int          s;
         int          w;
         logic [25:0] t;
         bit          found;
         s = (addr / BLK) % NSETS;
         t = addr / (BLK * NSETS);
         o = '0;
         found = 0;
         w = 0;
         for (int i = NWAYS - 1; i >= 0; i--) begin
            if (valid[s][i] && tags[s][i] == t) begin
               found = 1;
               w = i;
            end
         end
         if (found) begin
            o.hit = 1;
         end else if (cmd == CMD_WRITE && !alloc_mode) begin
            o.write_lower = 1;
         end else begin
            w = order[s][NWAYS-1];
            o.fetch_lower = 1;
            if (valid[s][w] && dirty[s][w]) begin
               o.evict_dirty = 1;
               o.victim_addr = 32'((tags[s][w] * NSETS + s) * BLK);
            end
            tags[s][w] = t;
            valid[s][w] = 1;
            dirty[s][w] = 0;
         end
         if (found || o.fetch_lower) begin
            touch(s, w);
            o.way_used = w[1:0];
            if (cmd == CMD_WRITE) begin
               if (through_mode) begin
                  o.write_lower = 1;
               end else begin
                  dirty[s][w] = 1;
               end
            end
         end
         pending.push_back(o);
      endfunction

      // Compare one response with the oldest queued outcome.
      function void check_response(outcome_type got);
         outcome_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected response, actual %p", $realtime, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.hit !== want.hit)
            $display("%0t: hit expected %0b actual %0b", $realtime, want.hit, got.hit);
         if (got.way_used !== want.way_used)
            $display("%0t: way_used expected %0d actual %0d", $realtime,
                     want.way_used, got.way_used);
         if (got.fetch_lower !== want.fetch_lower)
            $display("%0t: fetch_lower expected %0b actual %0b", $realtime,
                     want.fetch_lower, got.fetch_lower);
         if (got.write_lower !== want.write_lower)
            $display("%0t: write_lower expected %0b actual %0b", $realtime,
                     want.write_lower, got.write_lower);
         if (got.evict_dirty !== want.evict_dirty)
            $display("%0t: evict_dirty expected %0b actual %0b", $realtime,
                     want.evict_dirty, got.evict_dirty);
         if (got.victim_addr !== want.victim_addr)
            $display("%0t: victim_addr expected %h actual %h", $realtime,
                     want.victim_addr, got.victim_addr);
         if (got !== want) begin
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic        req_cmd = 0;
   logic [31:0] req_addr = '0;
   logic        rsp_strobe;
   logic        rsp_hit;
   logic [1:0]  rsp_way_used;
   logic        rsp_fetch_lower;
   logic        rsp_write_lower;
   logic        rsp_evict_dirty;
   logic [31:0] rsp_victim_addr;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic        csr_index = 0;
   logic [31:0] csr_wdata = '0;

   access_scoreboard board = new();

   set_assoc_cache_tag_controller dut (.*);

   always #1 clock = ~clock;

   // The receiver cannot stall, so every strobed cycle is one response
   // transaction, sampled at the edge that ends it.
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) begin
         board.check_response({rsp_hit, rsp_way_used, rsp_fetch_lower,
                                rsp_write_lower, rsp_evict_dirty, rsp_victim_addr});
      end
   end

   // Most gaps are short; an occasional long one lets the back end drain.
   // A nonzero gap drops start for its length.
   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) :
          (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 3));
      if (n > 0) begin
         start <= 0;
      end
      repeat (n) @(posedge clock);
   endtask

   // Present one access and hold it until the block takes it. The predictor
   // runs at the accepting edge so the shadow state follows the block's order.
   // Start stays high; the caller either sends again or drops it.
   task automatic send_access(logic cmd, logic [31:0] addr);
      start <= 1;
      req_cmd <= cmd;
      req_addr <= addr;
      do @(posedge clock); while (busy !== 1'b0);
      board.note_access(cmd, addr);
   endtask

   // Write one register; only called while nothing is in flight.
   task automatic write_register(logic idx, logic [31:0] value);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 0;
      if (idx == CSR_WT_MODE) begin
         board.through_mode = value[0];
      end else begin
         board.alloc_mode = value[0];
      end
      @(posedge clock);
   endtask

   // Wait until every expected response has come back, with start held low.
   task automatic drain();
      start <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Build an address from a tag, a set and an offset.
   function automatic logic [31:0] make_addr(logic [19:0] tag, int s, int off);
      return {tag, 6'(s), 6'(off)};
   endfunction

   // Random accesses mostly reuse a small pool of tags, in sets 0 to 3 half the
   // time, so hits, refills and dirty evictions all occur often; others are wild.
   task automatic random_phase(int count);
      logic [19:0] pool [6];
      int          s;
      for (int i = 0; i < 6; i++) pool[i] = 20'($urandom);
      pool[0] = '1;
      for (int i = 0; i < count; i++) begin
         s = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 63);
         if ($urandom_range(0, 9) == 0) begin
            send_access(1'($urandom_range(0, 1)), $urandom);
         end else begin
            send_access(1'($urandom_range(0, 1)),
                        make_addr(pool[$urandom_range(0, 5)], s, $urandom_range(0, 63)));
         end
         if ($urandom_range(0, 3) == 0) idle_gap();
      end
   endtask

   initial begin
      logic [1:0] modes [4];
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed part under reset modes (write-back, allocate): fill one set
      // past its ways so dirty victims come out, with extreme addresses.
      send_access(CMD_READ, 32'h0000_0000);
      send_access(CMD_WRITE, 32'hFFFF_FFFF);
      send_access(CMD_WRITE, 32'h0000_0003);
      for (int t = 1; t <= 5; t++) send_access(CMD_WRITE, make_addr(20'(t), 0, t));
      send_access(CMD_READ, make_addr(20'd4, 0, 63));
      send_access(CMD_READ, 32'hFFFF_FFC0);
      send_access(CMD_READ, 32'hAAAA_AAAA);
      send_access(CMD_WRITE, 32'h5555_5555);
      drain();

      // Write-through without allocate: hits pass through, misses bypass.
      write_register(CSR_WT_MODE, 32'hFFFF_FFFF);
      write_register(CSR_ALLOC_ON_WRITE, 32'h0000_0000);
      send_access(CMD_WRITE, make_addr(20'd4, 0, 0));
      send_access(CMD_WRITE, make_addr(20'd77, 0, 0));
      send_access(CMD_WRITE, 32'hFFFF_FFFF);
      send_access(CMD_READ, make_addr(20'd77, 0, 0));
      drain();

      // Random part, cycling through every mode combination.
      modes = '{2'b01, 2'b11, 2'b00, 2'b10};
      for (int p = 0; p < 8; p++) begin
         write_register(CSR_WT_MODE, {$urandom_range(0, 1) ? 31'h7FFF_FFFF : 31'h0,
                                      modes[p%4][1]});
         write_register(CSR_ALLOC_ON_WRITE, {31'(p * 12345), modes[p%4][0]});
         random_phase(225);
         drain();
      end

      if (board.errors == 0) begin
         $display("PASS set_assoc_cache_tag_controller");
      end else begin
         $display("FAIL set_assoc_cache_tag_controller");
      end
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #400000;
      $display("FAIL set_assoc_cache_tag_controller");
      $finish;
   end

endmodule
